// ----- src/nic_rx_ring_header_walk_top_defines.svh -----
// assertion macros for the receive ring header walk top
`ifndef NIC_RX_RING_HEADER_WALK_TOP_DEFINES_SVH
`define NIC_RX_RING_HEADER_WALK_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define NRHW_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nrhw assertion failed");

// next-cycle implication
`define NRHW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nrhw assertion failed");

`else

`define NRHW_ASSERT_IMPL(label, clk, rst, ante, cons)
`define NRHW_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- src/nrhw_pkg.sv -----
package nrhw_pkg;

   localparam int PAGE_SHIFT       = 8;
   localparam int HEADER_BYTES     = 4;
   localparam int MAX_PACKET_BYTES = 2048;
   localparam int PAGE_BYTES       = 256;

   localparam int PAGE_W = 8;
   localparam int ADDR_W = 16;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;

   localparam logic [PAGE_W-1:0] RESET_START_PAGE = 8'd76;
   localparam logic [PAGE_W-1:0] RESET_STOP_PAGE  = 8'd128;
   localparam logic [ADDR_W-1:0] RESET_BASE_ADDR  = 16'd19456;
   localparam logic [ADDR_W-1:0] RESET_END_ADDR   = 16'd32768;
   localparam logic [PAGE_W-1:0] RESET_NEXT_PAGE  = RESET_START_PAGE + 8'd1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RING_START_PAGE = 8'd0,
      CSR_RING_STOP_PAGE  = 8'd1,
      CSR_RING_BASE_ADDR  = 8'd2,
      CSR_RING_END_ADDR   = 8'd3
   } csr_index_type;

   typedef struct packed {
      logic [PAGE_W-1:0] start_page;
      logic [PAGE_W-1:0] stop_page;
      logic [ADDR_W-1:0] base_addr;
      logic [ADDR_W-1:0] end_addr;
   } ring_cfg_type;

   typedef struct packed {
      logic              packet_ok;
      logic              length_mismatch;
      logic [ADDR_W-1:0] data_addr;
      logic [ADDR_W-1:0] data_len;
      logic              wraps;
      logic [ADDR_W-1:0] first_seg_len;
      logic [PAGE_W-1:0] boundary_page;
      logic              more_pending;
   } rsp_type;

endpackage

// ----- src/nic_rx_ring_header_walk_top.sv -----
// Receive ring header walk. Each req transfer carries one ring header (next page pointer and
// byte count) plus the chip's current page; each produces exactly one rsp transfer with the
// validity flags, the data address and length, the wrap split of the copy and the new
// boundary page. While rsp_ready stays high the block sustains one header per cycle: a header
// is held in the input register, evaluated against the stored next-packet page in a single
// pass and lands in the result register, which drives rsp_valid. That rate is set by the
// next-page feedback loop, which closes within the single evaluation pass. A stalled rsp
// side holds the result register and, once the input register is also full, drops req_ready.
// The ring registers are written through the csr port (always ready); the user must write
// them only while the block is idle, the block does not enforce it; unknown indexes are ignored.
`include "nic_rx_ring_header_walk_top_defines.svh"

module nic_rx_ring_header_walk_top (
   input  logic        clock,
   input  logic        reset,

   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_data,

   // header input channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_hdr_next_page,
   input  logic [15:0] req_hdr_byte_count,
   input  logic [7:0]  req_chip_current_page,

   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_packet_ok,
   output logic        rsp_length_mismatch,
   output logic [15:0] rsp_data_addr,
   output logic [15:0] rsp_data_len,
   output logic        rsp_wraps,
   output logic [15:0] rsp_first_seg_len,
   output logic [7:0]  rsp_boundary_page,
   output logic        rsp_more_pending
);
   import nrhw_pkg::*;

   // ring configuration registers
   ring_cfg_type      cfg_ff;

   // walk state: page of the next header to read
   logic [PAGE_W-1:0] next_page_ff;
   logic [PAGE_W-1:0] next_page_in;

   // input register stage
   logic              in_valid_ff;
   logic [PAGE_W-1:0] hdr_next_page_ff;
   logic [ADDR_W-1:0] hdr_byte_count_ff;
   logic [PAGE_W-1:0] chip_current_page_ff;

   // result register stage
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;
   rsp_type           rsp_in;

   logic              advance;

   // header moves into the result register when that slot is free or being drained
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   // csr decode
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_page <= RESET_START_PAGE;
         cfg_ff.stop_page  <= RESET_STOP_PAGE;
         cfg_ff.base_addr  <= RESET_BASE_ADDR;
         cfg_ff.end_addr   <= RESET_END_ADDR;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_RING_START_PAGE: cfg_ff.start_page <= csr_data[PAGE_W-1:0];
            CSR_RING_STOP_PAGE:  cfg_ff.stop_page  <= csr_data[PAGE_W-1:0];
            CSR_RING_BASE_ADDR:  cfg_ff.base_addr  <= csr_data;
            CSR_RING_END_ADDR:   cfg_ff.end_addr   <= csr_data;
            default: ;
         endcase
      end
   end

   // input register, payload needs no reset
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         hdr_next_page_ff     <= req_hdr_next_page;
         hdr_byte_count_ff    <= req_hdr_byte_count;
         chip_current_page_ff <= req_chip_current_page;
      end
   end

   // single-pass header evaluation
   nrhw_calc u_calc (
      .cfg_i               (cfg_ff),
      .next_page_i         (next_page_ff),
      .hdr_next_page_i     (hdr_next_page_ff),
      .hdr_byte_count_i    (hdr_byte_count_ff),
      .chip_current_page_i (chip_current_page_ff),
      .rsp_o               (rsp_in),
      .next_page_o         (next_page_in)
   );

   // walk state advances together with the result transfer into the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         next_page_ff <= RESET_NEXT_PAGE;
      end else if (advance) begin
         next_page_ff <= next_page_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_packet_ok       = rsp_ff.packet_ok;
   assign rsp_length_mismatch = rsp_ff.length_mismatch;
   assign rsp_data_addr       = rsp_ff.data_addr;
   assign rsp_data_len        = rsp_ff.data_len;
   assign rsp_wraps           = rsp_ff.wraps;
   assign rsp_first_seg_len   = rsp_ff.first_seg_len;
   assign rsp_boundary_page   = rsp_ff.boundary_page;
   assign rsp_more_pending    = rsp_ff.more_pending;

   // a good packet never carries more data than the length limit allows
   `NRHW_ASSERT_IMPL(a_ok_len_limit, clock, reset, rsp_valid_ff && rsp_ff.packet_ok, rsp_ff.data_len <= ADDR_W'(MAX_PACKET_BYTES - HEADER_BYTES))
   // a rejected or empty header reports no copy
   `NRHW_ASSERT_IMPL(a_bad_no_copy, clock, reset, rsp_valid_ff && !rsp_ff.packet_ok, rsp_ff.data_addr == '0 && rsp_ff.data_len == '0 && !rsp_ff.wraps && rsp_ff.first_seg_len == '0)
   // without a wrap the whole copy is the first segment
   `NRHW_ASSERT_IMPL(a_nowrap_first, clock, reset, rsp_valid_ff && !rsp_ff.wraps, rsp_ff.first_seg_len == rsp_ff.data_len)
   // an evaluated header always leaves a result in the output register
   `NRHW_ASSERT_NEXT(a_advance_fills, clock, reset, advance, rsp_valid_ff)
   // walk state only moves when a header is evaluated
   `NRHW_ASSERT_NEXT(a_page_hold, clock, reset, !advance, $stable(next_page_ff))

endmodule

// ----- src/nrhw_calc.sv -----
module nrhw_calc (
   input  nrhw_pkg::ring_cfg_type cfg_i,
   input  logic [7:0]             next_page_i,
   input  logic [7:0]             hdr_next_page_i,
   input  logic [15:0]            hdr_byte_count_i,
   input  logic [7:0]             chip_current_page_i,
   output nrhw_pkg::rsp_type      rsp_o,
   output logic [7:0]             next_page_o
);
   import nrhw_pkg::*;

   logic              empty;
   logic [PAGE_W-1:0] dist_fwd;
   logic [PAGE_W-1:0] dist_wrap;
   logic [PAGE_W-1:0] page_dist;
   logic              tail_spill;
   logic [PAGE_W-1:0] pages;
   logic [ADDR_W-1:0] len;
   logic              good;
   logic [PAGE_W-1:0] page_ofs;
   logic [ADDR_W-1:0] hdr_addr;
   logic [ADDR_W-1:0] daddr;
   logic [ADDR_W-1:0] dlen;
   logic [ADDR_W:0]   span;
   logic              wrap;
   logic [ADDR_W-1:0] first;
   logic [PAGE_W-1:0] np_new;
   logic [PAGE_W-1:0] bnd_raw;
   logic              ok;

   always_comb begin
      empty     = (next_page_i == chip_current_page_i);

      // page distance, wrapping across the ring
      dist_fwd  = hdr_next_page_i - next_page_i;
      dist_wrap = (hdr_next_page_i - cfg_i.start_page) + (cfg_i.stop_page - next_page_i);
      page_dist = (hdr_next_page_i >= next_page_i) ? dist_fwd : dist_wrap;

      // header bytes spilling into another page cost one more page
      tail_spill = (hdr_byte_count_i[PAGE_SHIFT-1:0] >
                    PAGE_W'(PAGE_BYTES - HEADER_BYTES));
      pages = page_dist - PAGE_W'(1) - {{(PAGE_W-1){1'b0}}, tail_spill};
      len   = {pages, hdr_byte_count_i[PAGE_SHIFT-1:0]};

      good = (len <= ADDR_W'(MAX_PACKET_BYTES)) && (len >= ADDR_W'(HEADER_BYTES)) &&
             (hdr_next_page_i >= cfg_i.start_page) && (hdr_next_page_i < cfg_i.stop_page);
      ok   = !empty && good;

      page_ofs = next_page_i - cfg_i.start_page;
      hdr_addr = cfg_i.base_addr + {page_ofs, {PAGE_SHIFT{1'b0}}};
      daddr    = hdr_addr + ADDR_W'(HEADER_BYTES);
      dlen     = len - ADDR_W'(HEADER_BYTES);
      span     = {1'b0, daddr} + {1'b0, dlen};
      wrap     = (span > {1'b0, cfg_i.end_addr});
      if (!wrap) begin
         first = dlen;
      end else if (cfg_i.end_addr > daddr) begin
         first = cfg_i.end_addr - daddr;
      end else begin
         first = '0;
      end

      if (empty) begin
         np_new = next_page_i;
      end else if (good) begin
         np_new = hdr_next_page_i;
      end else begin
         np_new = cfg_i.start_page + PAGE_W'(1);
      end

      bnd_raw = np_new - PAGE_W'(1);

      rsp_o.packet_ok       = ok;
      rsp_o.length_mismatch = !empty && (len != hdr_byte_count_i);
      rsp_o.data_addr       = ok ? daddr : '0;
      rsp_o.data_len        = ok ? dlen : '0;
      rsp_o.wraps           = ok && wrap;
      rsp_o.first_seg_len   = ok ? first : '0;
      rsp_o.boundary_page   = (bnd_raw < cfg_i.start_page) ?
                              (cfg_i.stop_page - PAGE_W'(1)) : bnd_raw;
      rsp_o.more_pending    = !empty && (np_new != chip_current_page_i);
      next_page_o           = np_new;
   end

endmodule
